// ===== hw/rtl/rrd_pkg.sv =====
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared types and constants for the request deframer: phase codes, error
// codes, byte classes and framing characters.
// ----------------------------------------------------------------------------
package rrd_pkg;

    localparam int unsigned LINE_BITS = 21;

    localparam logic [LINE_BITS-1:0] LINE_SAT       = 21'h1F_FFFF;
    localparam logic [LINE_BITS-1:0] MAX_LINE_RESET = 21'd65536;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [9:0] {
        PH_STAR     = 10'b00_0000_0001,
        PH_COUNT    = 10'b00_0000_0010,
        PH_COUNT_LF = 10'b00_0000_0100,
        PH_DOLLAR   = 10'b00_0000_1000,
        PH_LEN      = 10'b00_0001_0000,
        PH_LEN_LF   = 10'b00_0010_0000,
        PH_PAYLOAD  = 10'b00_0100_0000,
        PH_PAY_CR   = 10'b00_1000_0000,
        PH_PAY_LF   = 10'b01_0000_0000,
        PH_ERROR    = 10'b10_0000_0000
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_NO_STAR     = 3'd1,
        ERR_NO_DOLLAR   = 3'd2,
        ERR_BAD_NUMBER  = 3'd3,
        ERR_NO_LF       = 3'd4,
        ERR_BAD_LENGTH  = 3'd5,
        ERR_NO_PAY_CRLF = 3'd6,
        ERR_LINE_LONG   = 3'd7
    } t_err;

    typedef enum logic [1:0] {
        CLS_COUNT_HDR = 2'd0,
        CLS_LEN_HDR   = 2'd1,
        CLS_PAYLOAD   = 2'd2,
        CLS_PAY_TERM  = 2'd3
    } t_class;

endpackage

// ===== hw/rtl/resp_request_deframer_core.sv =====
// ----------------------------------------------------------------------------
// resp_request_deframer_core
// Framing checker for a multi-bulk request byte stream. Echoes every beat
// with its class, argument index, a command-done flag and a sticky error.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  : i_in_valid / o_in_stall / i_byte_in, one byte per beat.
//   Output channel : o_out_valid / i_out_stall and the result fields, exactly
//                    one result beat per input beat, in order.
//   Config         : i_cfg_wr_en / i_cfg_wr_data write max_line_length; write
//                    only while the block is idle.
//   Path           : the input beat is held in the input register, then one
//                    pass of parse logic writes the result into the output
//                    register.
//   Throughput     : 1 beat per cycle while i_out_stall is low. The limit is
//                    the parser state update; digit accumulation is a
//                    shift-add by ten plus one compare.
//   Stall          : when the output register is held by i_out_stall the input
//                    register fills, and o_in_stall rises only once both hold
//                    a beat. No beat is dropped or repeated.
//   Reset          : synchronous, active low. Parser returns to "expect '*'",
//                    max_line_length returns to 65536, both channels empty.
//   Errors         : the first framing error is latched; every later beat
//                    reports it with class 0, argument 0 until reset.
// ----------------------------------------------------------------------------
module resp_request_deframer_core #(
    parameter int unsigned COUNT_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config
    input  logic                         i_cfg_wr_en,
    input  logic [rrd_pkg::LINE_BITS-1:0] i_cfg_wr_data,
    // input beats
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_byte_in,
    // result beats
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [7:0]                   o_byte_out,
    output logic [1:0]                   o_byte_class,
    output logic [15:0]                  o_arg_number,
    output logic                         o_command_done,
    output logic [2:0]                   o_error_code
);
    import rrd_pkg::*;

    localparam int unsigned PW = COUNT_BITS + 4;  // room for accum * 10 + digit
    localparam logic [PW-1:0] HALF = {{4{1'b0}}, 1'b1, {(COUNT_BITS-1){1'b0}}};

    // ---------------- handshake / pipeline control ----------------
    logic r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic r_out_valid, n_out_valid;
    logic out_free;   // output register can take a new result this cycle
    logic proc;       // the held input beat is parsed this cycle
    logic in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (proc) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (proc) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // ---------------- parser state ----------------
    t_phase                  r_phase, n_phase;
    logic [COUNT_BITS-1:0]   r_accum, n_accum;
    logic                    r_neg, n_neg;
    logic                    r_digit_seen, n_digit_seen;
    logic [COUNT_BITS-1:0]   r_args_left, n_args_left;
    logic [COUNT_BITS-1:0]   r_pay_left, n_pay_left;
    logic [LINE_BITS-1:0]    r_line, n_line;
    logic [15:0]             r_arg_index, n_arg_index;
    t_err                    r_err_held, n_err_held;
    logic [LINE_BITS-1:0]    r_max_line;

    // ---------------- header line byte (count or length line) ----------------
    logic                  is_digit;
    logic [3:0]            digit;
    logic [PW-1:0]         prod;      // accum * 10 + digit
    logic [PW-1:0]         limit;
    logic [LINE_BITS-1:0]  line_inc;
    t_err                  hdr_err;
    logic                  hdr_cr;
    logic                  hdr_neg;
    logic [COUNT_BITS-1:0] hdr_accum;
    logic                  hdr_digit;
    logic [LINE_BITS-1:0]  hdr_line;

    assign is_digit = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);
    assign digit    = r_in_byte[3:0];
    assign prod     = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0}
                    + {{(PW-4){1'b0}}, digit};
    assign limit    = r_neg ? HALF : (HALF - PW'(1));
    assign line_inc = (r_line < LINE_SAT) ? (r_line + LINE_BITS'(1)) : r_line;

    always_comb begin
        hdr_err   = ERR_NONE;
        hdr_cr    = 1'b0;
        hdr_neg   = r_neg;
        hdr_accum = r_accum;
        hdr_digit = r_digit_seen;
        hdr_line  = r_line;
        if (r_in_byte == CH_CR) begin
            hdr_cr = 1'b1;
            if (!r_digit_seen || (r_neg && r_accum == '0)) begin
                hdr_err = ERR_BAD_NUMBER;
            end
        end else begin
            hdr_line = line_inc;
            if (r_in_byte == CH_MINUS) begin
                if (r_digit_seen || r_neg) begin
                    hdr_err = ERR_BAD_NUMBER;
                end else begin
                    hdr_neg = 1'b1;
                end
            end else if (is_digit) begin
                // leading zero followed by more digits, or magnitude overflow
                if ((r_digit_seen && r_accum == '0) || (prod > limit)) begin
                    hdr_err = ERR_BAD_NUMBER;
                end else begin
                    hdr_accum = prod[COUNT_BITS-1:0];
                    hdr_digit = 1'b1;
                end
            end else begin
                hdr_err = ERR_BAD_NUMBER;
            end
            if (hdr_err == ERR_NONE && hdr_line > r_max_line) begin
                hdr_err = ERR_LINE_LONG;
            end
        end
    end

    // ---------------- main phase logic ----------------
    t_err                  err;
    t_class                cls;
    logic [15:0]           arg;
    logic                  done;
    logic                  marker_long;  // limit below one byte
    logic [COUNT_BITS-1:0] args_dec;
    logic [COUNT_BITS-1:0] pay_dec;

    assign marker_long = (r_max_line == '0);
    assign args_dec    = r_args_left - COUNT_BITS'(1);
    assign pay_dec     = r_pay_left - COUNT_BITS'(1);

    always_comb begin
        n_phase      = r_phase;
        n_accum      = r_accum;
        n_neg        = r_neg;
        n_digit_seen = r_digit_seen;
        n_args_left  = r_args_left;
        n_pay_left   = r_pay_left;
        n_line       = r_line;
        n_arg_index  = r_arg_index;
        n_err_held   = r_err_held;
        err          = ERR_NONE;
        cls          = CLS_COUNT_HDR;
        arg          = r_arg_index;
        done         = 1'b0;

        unique case (r_phase)
            PH_STAR, PH_DOLLAR: begin
                if (r_phase == PH_STAR) begin
                    arg = '0;
                end else begin
                    cls = CLS_LEN_HDR;
                end
                if (r_phase == PH_STAR && r_in_byte != CH_STAR) begin
                    err = ERR_NO_STAR;
                end else if (r_phase == PH_DOLLAR && r_in_byte != CH_DOLLAR) begin
                    err = ERR_NO_DOLLAR;
                end else begin
                    n_accum      = '0;
                    n_neg        = 1'b0;
                    n_digit_seen = 1'b0;
                    n_line       = LINE_BITS'(1);
                    if (marker_long) begin
                        err = ERR_LINE_LONG;
                    end else begin
                        n_phase = (r_phase == PH_STAR) ? PH_COUNT : PH_LEN;
                    end
                end
            end
            PH_COUNT, PH_LEN: begin
                if (r_phase == PH_COUNT) begin
                    arg = '0;
                end else begin
                    cls = CLS_LEN_HDR;
                end
                err          = hdr_err;
                n_accum      = hdr_accum;
                n_neg        = hdr_neg;
                n_digit_seen = hdr_digit;
                n_line       = hdr_line;
                if (hdr_cr && hdr_err == ERR_NONE) begin
                    n_phase = (r_phase == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
                end
            end
            PH_COUNT_LF: begin
                arg = '0;
                if (r_in_byte != CH_LF) begin
                    err = ERR_NO_LF;
                end else if (!r_neg && r_accum != '0) begin
                    n_args_left = r_accum;
                    n_arg_index = '0;
                    n_phase     = PH_DOLLAR;
                end else begin
                    // zero or negative count: empty command
                    done    = 1'b1;
                    n_phase = PH_STAR;
                end
            end
            PH_LEN_LF: begin
                cls = CLS_LEN_HDR;
                if (r_in_byte != CH_LF) begin
                    err = ERR_NO_LF;
                end else if (r_neg || r_accum == '0) begin
                    err = ERR_BAD_LENGTH;
                end else begin
                    n_pay_left = r_accum;
                    n_phase    = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                cls        = CLS_PAYLOAD;
                n_pay_left = pay_dec;
                if (pay_dec == '0) begin
                    n_phase = PH_PAY_CR;
                end
            end
            PH_PAY_CR: begin
                cls = CLS_PAY_TERM;
                if (r_in_byte != CH_CR) begin
                    err = ERR_NO_PAY_CRLF;
                end else begin
                    n_phase = PH_PAY_LF;
                end
            end
            PH_PAY_LF: begin
                cls = CLS_PAY_TERM;
                if (r_in_byte != CH_LF) begin
                    err = ERR_NO_PAY_CRLF;
                end else begin
                    n_args_left = args_dec;
                    if (args_dec == '0) begin
                        done        = 1'b1;
                        n_arg_index = '0;
                        n_phase     = PH_STAR;
                    end else begin
                        if (r_arg_index != 16'hFFFF) begin
                            n_arg_index = r_arg_index + 16'd1;
                        end
                        n_phase = PH_DOLLAR;
                    end
                end
            end
            default: begin
                // error hold, and any code outside the phase set
                arg = '0;
                err = r_err_held;
            end
        endcase

        // first error: latch it and park
        if (err != ERR_NONE && r_phase != PH_ERROR) begin
            n_err_held = err;
            n_phase    = PH_ERROR;
            done       = 1'b0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= PH_STAR;
            r_accum      <= '0;
            r_neg        <= 1'b0;
            r_digit_seen <= 1'b0;
            r_args_left  <= '0;
            r_pay_left   <= '0;
            r_line       <= '0;
            r_arg_index  <= '0;
            r_err_held   <= ERR_NONE;
            r_max_line   <= MAX_LINE_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_max_line <= i_cfg_wr_data;
            end
            if (proc) begin
                r_phase      <= n_phase;
                r_accum      <= n_accum;
                r_neg        <= n_neg;
                r_digit_seen <= n_digit_seen;
                r_args_left  <= n_args_left;
                r_pay_left   <= n_pay_left;
                r_line       <= n_line;
                r_arg_index  <= n_arg_index;
                r_err_held   <= n_err_held;
            end
        end
    end

    // payload registers, no reset
    logic [7:0]  r_out_byte;
    logic [1:0]  r_out_class;
    logic [15:0] r_out_arg;
    logic        r_out_done;
    logic [2:0]  r_out_err;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_byte_in;
        end
        if (proc) begin
            r_out_byte  <= r_in_byte;
            r_out_class <= cls;
            r_out_arg   <= arg;
            r_out_done  <= done;
            r_out_err   <= err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_out     = r_out_byte;
    assign o_byte_class   = r_out_class;
    assign o_arg_number   = r_out_arg;
    assign o_command_done = r_out_done;
    assign o_error_code   = r_out_err;

endmodule

// ===== hw/rtl/rrd_checker.sv =====
// ----------------------------------------------------------------------------
// rrd_checker
// Port-level checks for the request deframer, bound to the top level.
// ----------------------------------------------------------------------------
module rrd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [7:0]                    o_byte_out,
    input logic [1:0]                    o_byte_class,
    input logic [15:0]                   o_arg_number,
    input logic                          o_command_done,
    input logic [2:0]                    o_error_code
);
    import rrd_pkg::*;

    logic       out_beat;
    logic       r_err_seen;
    logic [2:0] r_err_val;

    assign out_beat = o_out_valid && !i_out_stall;

    // remember the first reported error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_seen <= 1'b0;
            r_err_val  <= ERR_NONE;
        end else if (out_beat && !r_err_seen && o_error_code != ERR_NONE) begin
            r_err_seen <= 1'b1;
            r_err_val  <= o_error_code;
        end
    end

    // error is sticky: later beats repeat the same code
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && r_err_seen |-> o_error_code == r_err_val)
        else $error("error code changed after first error");

    // a command only ends on the LF of a count line or a payload terminator
    a_done_on_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_command_done |->
            o_byte_out == CH_LF && o_error_code == ERR_NONE &&
            (o_byte_class == CLS_COUNT_HDR || o_byte_class == CLS_PAY_TERM))
        else $error("command_done on a byte that cannot end a command");

    // count header bytes never carry an argument index
    a_count_arg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_class == CLS_COUNT_HDR |-> o_arg_number == 16'd0)
        else $error("nonzero argument number on a count header byte");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_byte_out) && $stable(o_error_code) &&
            $stable(o_arg_number))
        else $error("stalled result changed");

endmodule

bind resp_request_deframer_core rrd_checker u_rrd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_byte_out     (o_byte_out),
    .o_byte_class   (o_byte_class),
    .o_arg_number   (o_arg_number),
    .o_command_done (o_command_done),
    .o_error_code   (o_error_code)
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for resp_request_deframer_core. A scoreboard class
// tracks the framing state of the request stream, predicts the echo of each
// accepted input beat, and compares it field by field with the result beats.
// Both channels idle and stall at random. max_line_length is rewritten
// between traffic phases. The run ends with one broken command, because the
// error latch only clears on reset, followed by noise that must echo the
// held error code.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rrd_pkg::*;

    localparam int unsigned COUNT_BITS     = 32;
    localparam int unsigned CLK_PERIOD     = 10;
    localparam int unsigned RESET_CYCLES   = 11;
    localparam int unsigned MAX_IDLE       = 14;
    localparam int unsigned DRAIN_CYCLES   = 4;     // pipeline is 2 deep
    localparam int unsigned END_CYCLES     = 10;
    localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no beat moving

    // Ways to end the run with a framing error; one is picked per seed.
    typedef enum int {
        BRK_NO_STAR,
        BRK_MARKER_LONG,
        BRK_LINE_LONG,
        BRK_NO_DOLLAR,
        BRK_LEADING_ZERO,
        BRK_MINUS_ZERO,
        BRK_EMPTY_NUMBER,
        BRK_DOUBLE_MINUS,
        BRK_MINUS_AFTER_DIGIT,
        BRK_NOT_A_DIGIT,
        BRK_OVERFLOW_POS,
        BRK_OVERFLOW_NEG,
        BRK_COUNT_NO_LF,
        BRK_LEN_NO_LF,
        BRK_LEN_ZERO,
        BRK_LEN_NEGATIVE,
        BRK_PAY_NO_CR,
        BRK_PAY_NO_LF,
        BRK_HUGE_COUNT,
        BRK_HUGE_LEN
    } t_break;

    // ------------------------------------------------------------------------
    // Scoreboard: framing state of the stream plus the queue of echoes that
    // are still owed by the block.
    // ------------------------------------------------------------------------
    class deframe_scoreboard;
        typedef struct {
            logic [7:0]  data;
            t_class      cls;
            logic [15:0] arg;
            logic        done;
            t_err        err;
        } t_echo;

        t_echo                expected_echoes[$];
        int unsigned          failures;
        logic [LINE_BITS-1:0] max_line;
        t_phase               ph;
        logic [63:0]          num_mag;
        bit                   num_neg;
        bit                   seen_digit;
        logic [63:0]          args_rem;
        logic [63:0]          pay_rem;
        logic [LINE_BITS-1:0] line_len;
        logic [15:0]          arg_idx;
        t_err                 held;

        function new();
            failures   = 0;
            max_line   = MAX_LINE_RESET;
            ph         = PH_STAR;
            num_mag    = '0;
            num_neg    = 1'b0;
            seen_digit = 1'b0;
            args_rem   = '0;
            pay_rem    = '0;
            line_len   = '0;
            arg_idx    = '0;
            held       = ERR_NONE;
        endfunction

        function void set_max_line(logic [LINE_BITS-1:0] value);
            max_line = value;
        endfunction

        function int unsigned pending();
            return expected_echoes.size();
        endfunction

        // '*' or '$' marker: fresh number, line length counts the marker
        function t_err open_line();
            num_mag    = '0;
            num_neg    = 1'b0;
            seen_digit = 1'b0;
            line_len   = LINE_BITS'(1);
            if (line_len > max_line) begin
                return ERR_LINE_LONG;
            end
            return ERR_NONE;
        endfunction

        // one byte of a count/length line after its marker
        function t_err header_char(logic [7:0] b);
            logic [63:0] half;
            logic [63:0] lim;
            logic [63:0] d;
            half = 64'd1 << (COUNT_BITS - 1);
            if (b == CH_CR) begin
                if (!seen_digit || (num_neg && num_mag == 0)) begin
                    return ERR_BAD_NUMBER;
                end
                if (ph == PH_COUNT) begin
                    ph = PH_COUNT_LF;
                end else begin
                    ph = PH_LEN_LF;
                end
                return ERR_NONE;
            end
            if (line_len != LINE_SAT) begin
                line_len = line_len + 1'b1;
            end
            if (b == CH_MINUS) begin
                if (seen_digit || num_neg) begin
                    return ERR_BAD_NUMBER;
                end
                num_neg = 1'b1;
            end else if (b >= CH_ZERO && b <= CH_NINE) begin
                d   = 64'(b - CH_ZERO);
                lim = num_neg ? half : half - 1;
                if (seen_digit && num_mag == 0) begin
                    return ERR_BAD_NUMBER;   // leading zero
                end
                if (num_mag > (lim - d) / 10) begin
                    return ERR_BAD_NUMBER;   // out of range
                end
                num_mag    = num_mag * 10 + d;
                seen_digit = 1'b1;
            end else begin
                return ERR_BAD_NUMBER;
            end
            // character check wins over the length check
            if (line_len > max_line) begin
                return ERR_LINE_LONG;
            end
            return ERR_NONE;
        endfunction

        // Advance the framing state by one byte and queue the echo it owes.
        function void accept_byte(logic [7:0] b);
            t_echo e;
            e.data = b;
            e.cls  = CLS_COUNT_HDR;
            e.arg  = arg_idx;
            e.done = 1'b0;
            e.err  = ERR_NONE;
            case (ph)
                PH_STAR: begin
                    e.arg = '0;
                    if (b != CH_STAR) begin
                        e.err = ERR_NO_STAR;
                    end else begin
                        e.err = open_line();
                    end
                    if (e.err == ERR_NONE) begin
                        ph = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    e.arg = '0;
                    e.err = header_char(b);
                end
                PH_COUNT_LF: begin
                    e.arg = '0;
                    if (b != CH_LF) begin
                        e.err = ERR_NO_LF;
                    end else if (!num_neg && num_mag > 0) begin
                        args_rem = num_mag;
                        arg_idx  = '0;
                        ph       = PH_DOLLAR;
                    end else begin
                        // zero or negative count: empty command
                        e.done = 1'b1;
                        ph     = PH_STAR;
                    end
                end
                PH_DOLLAR: begin
                    e.cls = CLS_LEN_HDR;
                    if (b != CH_DOLLAR) begin
                        e.err = ERR_NO_DOLLAR;
                    end else begin
                        e.err = open_line();
                    end
                    if (e.err == ERR_NONE) begin
                        ph = PH_LEN;
                    end
                end
                PH_LEN: begin
                    e.cls = CLS_LEN_HDR;
                    e.err = header_char(b);
                end
                PH_LEN_LF: begin
                    e.cls = CLS_LEN_HDR;
                    if (b != CH_LF) begin
                        e.err = ERR_NO_LF;
                    end else if (num_neg || num_mag == 0) begin
                        e.err = ERR_BAD_LENGTH;
                    end else begin
                        pay_rem = num_mag;
                        ph      = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    e.cls   = CLS_PAYLOAD;
                    pay_rem = pay_rem - 1;
                    if (pay_rem == 0) begin
                        ph = PH_PAY_CR;
                    end
                end
                PH_PAY_CR: begin
                    e.cls = CLS_PAY_TERM;
                    if (b != CH_CR) begin
                        e.err = ERR_NO_PAY_CRLF;
                    end else begin
                        ph = PH_PAY_LF;
                    end
                end
                PH_PAY_LF: begin
                    e.cls = CLS_PAY_TERM;
                    if (b != CH_LF) begin
                        e.err = ERR_NO_PAY_CRLF;
                    end else begin
                        args_rem = args_rem - 1;
                        if (args_rem == 0) begin
                            e.done  = 1'b1;
                            arg_idx = '0;
                            ph      = PH_STAR;
                        end else begin
                            if (arg_idx != 16'hFFFF) begin
                                arg_idx = arg_idx + 1'b1;
                            end
                            ph = PH_DOLLAR;
                        end
                    end
                end
                default: begin
                    // latched error: echo only
                    e.arg = '0;
                    e.err = held;
                end
            endcase
            if (e.err != ERR_NONE && ph != PH_ERROR) begin
                held   = e.err;
                ph     = PH_ERROR;
                e.done = 1'b0;
            end
            expected_echoes.push_back(e);
        endfunction

        function void check_beat(logic [7:0] data, logic [1:0] cls, logic [15:0] arg,
                                 logic done, logic [2:0] err);
            t_echo e;
            if (expected_echoes.size() == 0) begin
                $error("result beat with no byte outstanding: byte_out %0h", data);
                failures++;
                return;
            end
            e = expected_echoes.pop_front();
            if (data !== e.data) begin
                $error("byte_out: expected %0h, got %0h", e.data, data);
                failures++;
            end
            if (cls !== e.cls) begin
                $error("byte_class: expected %0d, got %0d", e.cls, cls);
                failures++;
            end
            if (arg !== e.arg) begin
                $error("arg_number: expected %0d, got %0d", e.arg, arg);
                failures++;
            end
            if (done !== e.done) begin
                $error("command_done: expected %0d, got %0d", e.done, done);
                failures++;
            end
            if (err !== e.err) begin
                $error("error_code: expected %0d, got %0d", e.err, err);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [LINE_BITS-1:0] cfg_wr_data = '0;
    logic                 in_valid    = 1'b0;
    logic [7:0]           byte_in     = '0;
    logic                 out_stall   = 1'b0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [7:0]           o_byte_out;
    logic [1:0]           o_byte_class;
    logic [15:0]          o_arg_number;
    logic                 o_command_done;
    logic [2:0]           o_error_code;

    // quiet: both sides run back to back, no idling
    bit                   quiet         = 1'b0;
    int unsigned          bytes_sent    = 0;
    int unsigned          stuck_cycles  = 0;
    logic [LINE_BITS-1:0] max_line_now  = MAX_LINE_RESET;

    deframe_scoreboard sb = new();

    always #(CLK_PERIOD / 2) clk = ~clk;

    resp_request_deframer_core #(
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_byte_in      (byte_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_byte_out     (o_byte_out),
        .o_byte_class   (o_byte_class),
        .o_arg_number   (o_arg_number),
        .o_command_done (o_command_done),
        .o_error_code   (o_error_code)
    );

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Valid stays up after a beat is taken; the next call either keeps it up
    // (no gap) or drops it, so it gets a single update per edge.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        do @(posedge clk); while (o_in_stall !== 1'b0);
        sb.accept_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    task automatic send_crlf();
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_line(input string s);
        send_text(s);
        send_crlf();
    endtask

    function automatic logic [7:0] other_than(input logic [7:0] avoid);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == avoid);
        return b;
    endfunction

    // anything the number parser rejects on sight
    function automatic logic [7:0] not_number_char();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS || b == CH_CR);
        return b;
    endfunction

    // characters allowed after the marker under the current line limit
    function automatic int unsigned header_room();
        return (max_line_now - 1 > 9) ? 9 : int'(max_line_now) - 1;
    endfunction

    // Let the pipeline empty; valid drops on the step of the last beat.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_line(input logic [LINE_BITS-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        max_line_now = value;
        sb.set_max_line(value);
    endtask

    // One well-formed command whose header lines fit the current limit.
    task automatic send_command();
        int unsigned room;
        int unsigned n;
        int unsigned len;
        room = header_room();
        if ($urandom_range(0, 9) == 0) begin
            // empty command: zero or negative count
            if (room >= 2 && $urandom_range(0, 1) == 1) begin
                send_line($sformatf("*-%0d", $urandom_range(1, room >= 3 ? 99 : 9)));
            end else begin
                send_line("*0");
            end
            return;
        end
        n = $urandom_range(1, 4);
        send_line($sformatf("*%0d", n));
        repeat (n) begin
            if (room >= 3 && $urandom_range(0, 7) == 0) begin
                len = $urandom_range(21, 300);
            end else begin
                len = $urandom_range(1, room >= 2 ? 20 : 9);
            end
            send_line($sformatf("$%0d", len));
            repeat (len) send_byte(8'($urandom_range(0, 255)));
            send_crlf();
        end
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned stop_at;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at) begin
            quiet <= ($urandom_range(0, 3) == 0);
            send_command();
        end
    endtask

    // Last command of the run: break the framing one way, then noise that
    // must come back with the latched code.
    task automatic send_broken_tail();
        t_break     kind;
        logic [7:0] marker;
        kind   = t_break'($urandom_range(BRK_NO_STAR, BRK_HUGE_LEN));
        marker = CH_STAR;
        quiet <= ($urandom_range(0, 1) == 0);
        send_command();
        case (kind)
            // limit of one: the character check must win where both apply
            BRK_NO_STAR, BRK_MARKER_LONG, BRK_EMPTY_NUMBER, BRK_DOUBLE_MINUS,
            BRK_NOT_A_DIGIT: write_max_line(LINE_BITS'(1));
            BRK_LINE_LONG:   write_max_line(LINE_BITS'($urandom_range(2, 8)));
            default:         write_max_line(LINE_BITS'($urandom_range(16, 1048576)));
        endcase
        case (kind)
            BRK_NO_STAR: send_byte(other_than(CH_STAR));
            BRK_MARKER_LONG: begin
                send_text("*");
                send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
            end
            BRK_LINE_LONG: begin
                if ($urandom_range(0, 1) == 1) begin
                    send_line("*1");
                    marker = CH_DOLLAR;
                end
                send_byte(marker);
                repeat (max_line_now) send_byte(8'(CH_ZERO + $urandom_range(1, 9)));
            end
            BRK_NO_DOLLAR: begin
                send_line("*1");
                send_byte(other_than(CH_DOLLAR));
            end
            BRK_LEADING_ZERO: send_text("*01");
            BRK_MINUS_ZERO: begin
                send_text("*-0");
                send_byte(CH_CR);
            end
            BRK_EMPTY_NUMBER: begin
                send_text("*");
                send_byte(CH_CR);
            end
            BRK_DOUBLE_MINUS:      send_text("*--");
            BRK_MINUS_AFTER_DIGIT: send_text("*3-");
            BRK_NOT_A_DIGIT: begin
                send_text("*");
                send_byte(not_number_char());
            end
            BRK_OVERFLOW_POS: send_text("*2147483648");
            BRK_OVERFLOW_NEG: send_text("*-2147483649");
            BRK_COUNT_NO_LF: begin
                send_text("*1");
                send_byte(CH_CR);
                send_byte(other_than(CH_LF));
            end
            BRK_LEN_NO_LF: begin
                send_line("*1");
                send_text("$1");
                send_byte(CH_CR);
                send_byte(other_than(CH_LF));
            end
            BRK_LEN_ZERO: begin
                send_line("*1");
                send_line("$0");
            end
            BRK_LEN_NEGATIVE: begin
                send_line("*1");
                send_line("$-5");
            end
            BRK_PAY_NO_CR: begin
                send_line("*1");
                send_line("$1");
                send_text("x");
                send_byte(other_than(CH_CR));
            end
            BRK_PAY_NO_LF: begin
                send_line("*1");
                send_line("$1");
                send_text("x");
                send_byte(CH_CR);
                send_byte(other_than(CH_LF));
            end
            BRK_HUGE_COUNT: begin
                // largest count accepted, then a payload that misses its CR
                send_line("*2147483647");
                send_line("$1");
                send_text("ab");
            end
            default: begin
                // largest length accepted; the payload simply runs on
                send_line("*1");
                send_line("$2147483647");
            end
        endcase
        repeat (40) send_byte(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall per beat, every beat checked
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold;
        forever begin
            hold = quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (o_out_valid !== 1'b1 || out_stall !== 1'b0);
            sb.check_beat(o_byte_out, o_byte_class, o_arg_number, o_command_done,
                          o_error_code);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: no beat on either channel for too long means a hang
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if ((in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset limit: empty commands, most negative count,
        // payload extremes
        send_line("*0");
        send_line("*-2147483648");
        send_line("*1");
        send_line("$2");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_crlf();

        // large limit, 2^20
        write_max_line(21'd1048576);
        run_random(500);

        // tight limits: a limit of 2 allows single digit numbers only
        write_max_line(21'd2);
        run_random(400);
        write_max_line(LINE_BITS'($urandom_range(3, 6)));
        run_random(400);
        write_max_line(21'h0F_FFFF);
        run_random(700);

        send_broken_tail();

        settle();
        repeat (END_CYCLES) @(posedge clk);
        if (sb.failures == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/rrd_pkg.sv
hw/rtl/resp_request_deframer_core.sv
hw/rtl/rrd_checker.sv
verif/testbench.sv
